// ===== hw/rtl/frustum_box_classifier_unit_assert.svh =====
// ------------------------------------------------------------------------
// frustum box classifier assertion macros
// shared property forms for the checker of the classifier unit
// ------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CLASSIFIER_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define FBC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fbc check failed: same-cycle implication");

// next-cycle implication, off while reset is asserted
`define FBC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fbc check failed: next-cycle implication");

`endif

// ===== hw/rtl/fbc_pkg.sv =====
// ------------------------------------------------------------------------
// fbc_pkg
// widths, plane layout and verdict codes of the frustum box classifier
// ------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

    // input coordinates and margin
    localparam int COORD_W   = 24;
    localparam int MARGIN_W  = 23;
    localparam int WIDE_W    = COORD_W + 1;

    // plane register layout
    localparam int PLANE_W   = 64;
    localparam int NORM_W    = 14;
    localparam int OFFS_W    = 22;
    localparam int OFFS_LSB  = 3 * NORM_W;
    localparam int OFFS_SHL  = 12;

    // arithmetic widths
    localparam int PROD_W    = NORM_W + WIDE_W;
    localparam int DIST_W    = PROD_W + 2;

    // plane registers and planes tested
    localparam int NUM_REGS      = 6;
    localparam int PLANE_COUNT   = 6;
    localparam int ACTIVE_PLANES = (PLANE_COUNT < NUM_REGS) ? PLANE_COUNT : NUM_REGS;
    localparam int NUM_AXES      = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PLANE_W;

    localparam int VERDICT_W = 2;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

    function automatic logic signed [NORM_W-1:0] norm_of(input logic [PLANE_W-1:0] plane,
                                                         input int unsigned axis);
        return plane[axis*NORM_W +: NORM_W];
    endfunction

    function automatic logic signed [OFFS_W-1:0] offset_of(input logic [PLANE_W-1:0] plane);
        return plane[OFFS_LSB +: OFFS_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fbc_box_if.sv =====
// ------------------------------------------------------------------------
// fbc_box_if
// box channel: valid/ready handshake with both box corners and the margin
// ------------------------------------------------------------------------
`default_nettype none

interface fbc_box_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fbc_pkg::COORD_W-1:0]   box_min_x;
    logic signed [fbc_pkg::COORD_W-1:0]   box_min_y;
    logic signed [fbc_pkg::COORD_W-1:0]   box_min_z;
    logic signed [fbc_pkg::COORD_W-1:0]   box_max_x;
    logic signed [fbc_pkg::COORD_W-1:0]   box_max_y;
    logic signed [fbc_pkg::COORD_W-1:0]   box_max_z;
    logic        [fbc_pkg::MARGIN_W-1:0]  margin;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
        output box_max_x, box_max_y, box_max_z, margin,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
        input  box_max_x, box_max_y, box_max_z, margin,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/fbc_verdict_if.sv =====
// ------------------------------------------------------------------------
// fbc_verdict_if
// result channel: valid/ready handshake with the classification verdict
// ------------------------------------------------------------------------
`default_nettype none

interface fbc_verdict_if;
    logic                               valid;
    logic                               ready;
    logic [fbc_pkg::VERDICT_W-1:0]      verdict;

    modport source (
        output valid, verdict,
        input  ready
    );

    modport sink (
        input  valid, verdict,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/frustum_box_classifier_unit.sv =====
// ------------------------------------------------------------------------
// frustum_box_classifier_unit
// classifies a margin-widened axis-aligned box against the frustum planes
// with the positive/negative vertex test
// ------------------------------------------------------------------------
//
//  channel   dir  handshake           contents
//  --------  ---  ------------------  -----------------------------------
//  box       in   valid/ready         box min/max corners, margin
//  result    out  valid/ready         verdict (outside/intersect/inside)
//  cfg       in   cfg_we, no stall    plane register index and data
//
//  one box per cycle while the result is taken; four register stages
//  (widen, vertex multiply, plane sum, verdict), and a taken box passes
//  through all four of them before its verdict can transfer on the result
//  each stage holds its own valid bit and moves on whenever the stage
//  after it is empty or moving, so a stalled result only blocks the boxes
//  behind it and gaps in the stream are filled up
//  rst_n clears stage valid bits and the plane registers to zero
//  plane registers are read straight by the multiply and sum stages
//
`default_nettype none

module frustum_box_classifier_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    fbc_box_if.sink                         box,
    fbc_verdict_if.source                   result
);

    // plane registers
    logic [fbc_pkg::PLANE_W-1:0] plane_reg [fbc_pkg::NUM_REGS];

    // stage valid bits and per-stage advance
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    // stage 1: widened corners
    logic signed [fbc_pkg::WIDE_W-1:0] lo_reg  [fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::WIDE_W-1:0] hi_reg  [fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::WIDE_W-1:0] lo_next [fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::WIDE_W-1:0] hi_next [fbc_pkg::NUM_AXES];

    // stage 2: per plane, per axis products of both vertices
    logic signed [fbc_pkg::PROD_W-1:0]
        pos_prod_reg  [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::PROD_W-1:0]
        neg_prod_reg  [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::PROD_W-1:0]
        pos_prod_next [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_AXES];
    logic signed [fbc_pkg::PROD_W-1:0]
        neg_prod_next [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_AXES];

    // stage 3: behind flags per plane
    logic [fbc_pkg::ACTIVE_PLANES-1:0] pos_behind_reg, pos_behind_next;
    logic [fbc_pkg::ACTIVE_PLANES-1:0] neg_behind_reg, neg_behind_next;

    // stage 4: verdict output register
    fbc_pkg::verdict_t verdict_reg, verdict_next;

    // ready chain: a stage takes new data when empty or when it empties
    assign s4_rdy    = !s4_valid_reg || result.ready;
    assign s3_rdy    = !s3_valid_reg || s4_rdy;
    assign s2_rdy    = !s2_valid_reg || s3_rdy;
    assign s1_rdy    = !s1_valid_reg || s2_rdy;
    assign box.ready = s1_rdy;

    assign result.valid   = s4_valid_reg;
    assign result.verdict = verdict_reg;

    // plane register writes, indices past the last plane are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::NUM_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < fbc_pkg::CFG_IDX_W'(fbc_pkg::NUM_REGS)))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // widen by the margin; the guard bit keeps the result exact
    always_comb
    begin
        lo_next[0] = fbc_pkg::WIDE_W'(box.box_min_x) - fbc_pkg::WIDE_W'(box.margin);
        lo_next[1] = fbc_pkg::WIDE_W'(box.box_min_y) - fbc_pkg::WIDE_W'(box.margin);
        lo_next[2] = fbc_pkg::WIDE_W'(box.box_min_z) - fbc_pkg::WIDE_W'(box.margin);
        hi_next[0] = fbc_pkg::WIDE_W'(box.box_max_x) + fbc_pkg::WIDE_W'(box.margin);
        hi_next[1] = fbc_pkg::WIDE_W'(box.box_max_y) + fbc_pkg::WIDE_W'(box.margin);
        hi_next[2] = fbc_pkg::WIDE_W'(box.box_max_z) + fbc_pkg::WIDE_W'(box.margin);
    end

    // vertex selection from the normal signs and the products
    // positive vertex: upper corner where the component is above zero
    // negative vertex: upper corner where the component is below zero
    always_comb
    begin
        logic signed [fbc_pkg::NORM_W-1:0] n;
        logic signed [fbc_pkg::WIDE_W-1:0] pv;
        logic signed [fbc_pkg::WIDE_W-1:0] nv;
        n  = '0;
        pv = '0;
        nv = '0;
        for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++)
        begin
            for (int a = 0; a < fbc_pkg::NUM_AXES; a++)
            begin
                n  = fbc_pkg::norm_of(plane_reg[p], a);
                pv = (!n[fbc_pkg::NORM_W-1] && (n != '0)) ? hi_reg[a] : lo_reg[a];
                nv = n[fbc_pkg::NORM_W-1] ? hi_reg[a] : lo_reg[a];
                pos_prod_next[p][a] = fbc_pkg::PROD_W'(n) * fbc_pkg::PROD_W'(pv);
                neg_prod_next[p][a] = fbc_pkg::PROD_W'(n) * fbc_pkg::PROD_W'(nv);
            end
        end
    end

    // plane distance in Q.20, offset brought up from Q.8; sign is behind
    always_comb
    begin
        logic signed [fbc_pkg::DIST_W-1:0] off;
        logic signed [fbc_pkg::DIST_W-1:0] pd;
        logic signed [fbc_pkg::DIST_W-1:0] nd;
        off = '0;
        pd  = '0;
        nd  = '0;
        for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++)
        begin
            off = fbc_pkg::DIST_W'(fbc_pkg::offset_of(plane_reg[p])) <<< fbc_pkg::OFFS_SHL;
            pd  = off + fbc_pkg::DIST_W'(pos_prod_reg[p][0])
                      + fbc_pkg::DIST_W'(pos_prod_reg[p][1])
                      + fbc_pkg::DIST_W'(pos_prod_reg[p][2]);
            nd  = off + fbc_pkg::DIST_W'(neg_prod_reg[p][0])
                      + fbc_pkg::DIST_W'(neg_prod_reg[p][1])
                      + fbc_pkg::DIST_W'(neg_prod_reg[p][2]);
            pos_behind_next[p] = pd[fbc_pkg::DIST_W-1];
            neg_behind_next[p] = nd[fbc_pkg::DIST_W-1];
        end
    end

    // any positive vertex behind wins over any negative vertex behind
    always_comb
    begin
        if (|pos_behind_reg)
        begin
            verdict_next = fbc_pkg::VERDICT_OUTSIDE;
        end
        else if (|neg_behind_reg)
        begin
            verdict_next = fbc_pkg::VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = fbc_pkg::VERDICT_INSIDE;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= box.valid;
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_rdy)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage payloads, loaded only on a real move
    always_ff @(posedge clk)
    begin
        if (s1_rdy && box.valid)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (s2_rdy && s1_valid_reg)
        begin
            pos_prod_reg <= pos_prod_next;
            neg_prod_reg <= neg_prod_next;
        end
        if (s3_rdy && s2_valid_reg)
        begin
            pos_behind_reg <= pos_behind_next;
            neg_behind_reg <= neg_behind_next;
        end
        if (s4_rdy && s3_valid_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbc_checker.sv =====
// ------------------------------------------------------------------------
// fbc_checker
// port-level checks on the frustum box classifier unit, bound to the unit
// ------------------------------------------------------------------------
`default_nettype none

`include "frustum_box_classifier_unit_assert.svh"

module fbc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [fbc_pkg::VERDICT_W-1:0]   out_verdict
);

    // a stalled result holds
    `FBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_verdict))

    // an open sink lets every stage move, so boxes are taken
    `FBC_ASSERT_SAME(a_ready_flow, clk, rst_n, out_ready, in_ready)

    // a taken box passes the four stages to a valid result when the sink keeps taking
    `FBC_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind frustum_box_classifier_unit fbc_checker u_fbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (box.valid),
    .in_ready    (box.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_verdict (result.verdict)
);

`default_nettype wire
